### sv/arfp_pkg.sv
// ----------------------------------------------------------------------------
// arfp_pkg: shared types and constants of the audio reply frame parser
// Header codes, field codes and the structs passed between the parser stages.
// ----------------------------------------------------------------------------
`default_nettype none

package arfp_pkg;

  localparam logic [7:0] HDR_STATUS     = 8'hA3;
  localparam logic [7:0] HDR_EQ         = 8'hA4;
  localparam logic [7:0] HDR_DIR        = 8'hAD;
  localparam logic [7:0] NO_STATUS_MARK = 8'hFF;

  localparam int unsigned WIN_DEPTH = 4;
  localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_EQ     = 2'd1;
  localparam logic [1:0] KIND_DIR    = 2'd2;

  localparam logic [3:0] EQ_NIB_MAX = 4'd5;
  localparam logic [2:0] EQ_UNKNOWN = 3'd6;

  localparam logic [3:0] SRC_NIB_FM  = 4'h5;
  localparam logic [3:0] SRC_NIB_MP3 = 4'h3;
  localparam logic [3:0] SRC_NIB_DVD = 4'h6;

  localparam logic [1:0] SRC_FM      = 2'd0;
  localparam logic [1:0] SRC_MP3     = 2'd1;
  localparam logic [1:0] SRC_DVD     = 2'd2;
  localparam logic [1:0] SRC_UNKNOWN = 2'd3;

  typedef struct packed {
    logic       hit;
    logic [7:0] hdr;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } frame_t;

  typedef struct packed {
    logic [1:0] frame_kind;
    logic       has_status;
    logic [7:0] volume;
    logic [2:0] eq_mode;
    logic [3:0] eq_nibble;
    logic [1:0] source_sel;
    logic [3:0] source_nibble;
  } result_t;

endpackage

`default_nettype wire

### sv/arfp_window.sv
// ----------------------------------------------------------------------------
// arfp_window: five-byte sliding window and frame check
// Holds four earlier bytes, checks header and checksum against the new byte.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_window (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      byte_i,
  input  wire logic            consume_i,
  output arfp_pkg::frame_t     frame_o
);

  logic [arfp_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [7:0]                  win_q [arfp_pkg::WIN_DEPTH];
  logic                        full;
  logic                        hdr_ok;
  logic                        sum_ok;

  assign full   = (fill_q == arfp_pkg::FILL_W'(arfp_pkg::WIN_DEPTH));
  assign hdr_ok = (win_q[0] == arfp_pkg::HDR_STATUS) || (win_q[0] == arfp_pkg::HDR_EQ) ||
                  (win_q[0] == arfp_pkg::HDR_DIR);
  assign sum_ok = (byte_i == (win_q[1] ^ win_q[2] ^ win_q[3]));

  assign frame_o.hit = full && hdr_ok && sum_ok;
  assign frame_o.hdr = win_q[0];
  assign frame_o.b1  = win_q[1];
  assign frame_o.b2  = win_q[2];
  assign frame_o.b3  = win_q[3];

  always_comb begin
    fill_d = fill_q;
    if (consume_i) begin
      if (!full) begin
        fill_d = fill_q + 1'b1;
      end else if (frame_o.hit) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // held bytes past the fill level are never read, so they need no reset
  always_ff @(posedge clk_i) begin
    if (consume_i) begin
      if (!full) begin
        win_q[fill_q[arfp_pkg::WIN_IDX_W-1:0]] <= byte_i;
      end else if (!frame_o.hit) begin
        for (int i = 0; i < arfp_pkg::WIN_DEPTH - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[arfp_pkg::WIN_DEPTH-1] <= byte_i;
      end
    end
  end

endmodule

`default_nettype wire

### sv/arfp_decode.sv
// ----------------------------------------------------------------------------
// arfp_decode: reply field decoder
// Maps an accepted frame to kind, volume, equalizer and source fields.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_decode (
  input  arfp_pkg::frame_t  frame_i,
  output arfp_pkg::result_t res_o
);

  logic [3:0] hi;
  logic [3:0] lo;
  logic [1:0] kind;
  logic       status;
  logic [1:0] src;

  assign hi = frame_i.b3[7:4];
  assign lo = frame_i.b3[3:0];

  always_comb begin
    case (frame_i.hdr)
      arfp_pkg::HDR_STATUS: kind = arfp_pkg::KIND_STATUS;
      arfp_pkg::HDR_EQ:     kind = arfp_pkg::KIND_EQ;
      default:              kind = arfp_pkg::KIND_DIR;
    endcase
  end

  always_comb begin
    case (lo)
      arfp_pkg::SRC_NIB_FM:  src = arfp_pkg::SRC_FM;
      arfp_pkg::SRC_NIB_MP3: src = arfp_pkg::SRC_MP3;
      arfp_pkg::SRC_NIB_DVD: src = arfp_pkg::SRC_DVD;
      default:               src = arfp_pkg::SRC_UNKNOWN;
    endcase
  end

  assign status = (kind != arfp_pkg::KIND_DIR) && (frame_i.b2 != arfp_pkg::NO_STATUS_MARK);

  // frames without status carry zeros in every status field
  always_comb begin
    res_o            = '0;
    res_o.frame_kind = kind;
    if (status) begin
      res_o.has_status    = 1'b1;
      res_o.volume        = frame_i.b1;
      res_o.eq_mode       = (hi <= arfp_pkg::EQ_NIB_MAX) ? hi[2:0] : arfp_pkg::EQ_UNKNOWN;
      res_o.eq_nibble     = hi;
      res_o.source_sel    = src;
      res_o.source_nibble = lo;
    end
  end

endmodule

`default_nettype wire

### sv/audio_reply_frame_parser_core.sv
// ----------------------------------------------------------------------------
// audio_reply_frame_parser_core: audio device reply frame parser
// Finds checksummed five-byte reply frames in a received byte stream.
// ----------------------------------------------------------------------------
// Usage
//   slave stream: one received byte per transfer on s_axis_tdata[7:0].
//   master stream: one transfer per accepted frame; frame kind on tuser,
//   status fields on tdata. Bytes that do not complete a frame give nothing.
// Pipeline
//   a byte sits in the input register while the window check and field
//   decode run on it; the result of a frame it completes is registered in
//   the result register, which drives the master side.
// Throughput
//   one byte per cycle while no frame-completing byte waits on the result
//   side, set by the window update between the input and result registers.
// Reset
//   rst_ni clears the fill level, the input valid and the result valid;
//   parsing starts over with an empty window.
// Stall
//   while a result waits on m_axis_tready, bytes that make no frame keep
//   flowing; a byte that completes a frame waits in the input register and
//   s_axis_tready stays low until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_reply_frame_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // has_status, volume, eq_mode, eq_nibble,
                                           // source_sel, source_nibble, zero fill
  output      logic [1:0]  m_axis_tuser    // frame_kind
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  arfp_pkg::result_t out_res_q;
  arfp_pkg::frame_t  frame;
  arfp_pkg::result_t res;
  logic              out_free;
  logic              advance;

  arfp_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .consume_i (advance),
    .frame_o   (frame)
  );

  arfp_decode u_decode (
    .frame_i (frame),
    .res_o   (res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!frame.hit || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign out_valid_d   = out_free ? (advance && frame.hit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && frame.hit) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.frame_kind;
  assign m_axis_tdata  = {2'b00, out_res_q.source_nibble, out_res_q.source_sel,
                          out_res_q.eq_nibble, out_res_q.eq_mode, out_res_q.volume,
                          out_res_q.has_status};

endmodule

`default_nettype wire

### sv/arfp_checker.sv
// ----------------------------------------------------------------------------
// arfp_checker: port-level checks of the reply frame parser
// Watches the result stream for stall holding and consistent field codes.
// ----------------------------------------------------------------------------
`default_nettype none

module arfp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // directory replies never carry status, and kind three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != arfp_pkg::KIND_DIR || !m_axis_tdata[0]) &&
                      (m_axis_tuser != 2'd3))
    else $error("bad frame kind or status");

  // no status means all status fields zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[23:1] == 23'd0)
    else $error("status fields set without status");

  // equalizer code follows its raw nibble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      ((m_axis_tdata[15:12] <= arfp_pkg::EQ_NIB_MAX) ?
        (m_axis_tdata[11:9] == m_axis_tdata[14:12]) :
        (m_axis_tdata[11:9] == arfp_pkg::EQ_UNKNOWN)))
    else $error("equalizer code does not match nibble");

endmodule

bind audio_reply_frame_parser_core arfp_checker u_arfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the audio reply frame parser
// Streams received bytes into the parser: a few hand-built frames first, then
// random well-formed frames mixed with noise and broken checksums. Each byte
// that goes in also goes through a window predictor kept here, and every
// frame the parser reports is compared field by field with the oldest
// predicted frame. Both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int unsigned RANDOM_BYTES = 1900;
  localparam int unsigned TAIL_BYTES   = 250;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RUN_LIMIT    = 2000000;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  logic [7:0]        rx_bytes_q [$];
  arfp_pkg::result_t frames_due [$];

  // predictor copy of the byte window
  logic [7:0]                  win [arfp_pkg::WIN_DEPTH];
  logic [arfp_pkg::FILL_W-1:0] fill = '0;

  int unsigned errors      = 0;
  int unsigned bytes_sent  = 0;
  int unsigned frames_seen = 0;
  int unsigned status_seen = 0;
  int unsigned src_gap  = 0;
  int unsigned src_calm = 0;
  int unsigned snk_gap  = 0;
  int unsigned snk_calm = 0;

  audio_reply_frame_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // add a byte to the window, sliding it once full, and queue the frame it completes, if any
  task automatic parse_rx_byte(input logic [7:0] b);
    arfp_pkg::result_t r;
    logic [7:0]        hdr;
    logic [3:0]        hi;
    logic [3:0]        lo;
    hdr = win[0];
    if (fill < arfp_pkg::WIN_DEPTH) begin
      win[fill[arfp_pkg::WIN_IDX_W-1:0]] = b;
      fill++;
    end else if (!(hdr == arfp_pkg::HDR_STATUS || hdr == arfp_pkg::HDR_EQ ||
                   hdr == arfp_pkg::HDR_DIR) ||
                 b != (win[1] ^ win[2] ^ win[3])) begin
      // resync: drop the oldest byte
      win[0] = win[1];
      win[1] = win[2];
      win[2] = win[3];
      win[3] = b;
    end else begin
      r = '0;
      r.frame_kind = (hdr == arfp_pkg::HDR_STATUS) ? arfp_pkg::KIND_STATUS :
                     (hdr == arfp_pkg::HDR_EQ)     ? arfp_pkg::KIND_EQ     :
                                                     arfp_pkg::KIND_DIR;
      if (hdr != arfp_pkg::HDR_DIR && win[2] != arfp_pkg::NO_STATUS_MARK) begin
        hi = win[3][7:4];
        lo = win[3][3:0];
        r.has_status    = 1'b1;
        r.volume        = win[1];
        r.eq_mode       = (hi <= arfp_pkg::EQ_NIB_MAX) ? hi[2:0] : arfp_pkg::EQ_UNKNOWN;
        r.eq_nibble     = hi;
        r.source_nibble = lo;
        case (lo)
          arfp_pkg::SRC_NIB_FM:  r.source_sel = arfp_pkg::SRC_FM;
          arfp_pkg::SRC_NIB_MP3: r.source_sel = arfp_pkg::SRC_MP3;
          arfp_pkg::SRC_NIB_DVD: r.source_sel = arfp_pkg::SRC_DVD;
          default:               r.source_sel = arfp_pkg::SRC_UNKNOWN;
        endcase
      end
      frames_due.push_back(r);
      for (int i = 0; i < arfp_pkg::WIN_DEPTH; i++) win[i] = 8'h00;
      fill = '0;
    end
  endtask

  // driver: holds a byte until it is taken, idles in bursts until the tail
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
        bytes_sent++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() > TAIL_BYTES && src_calm == 0 &&
                     $urandom_range(0, 5) == 0) begin
          src_gap  = $urandom_range(1, 10) - 1;
          src_calm = $urandom_range(0, 40);
          s_tvalid <= 1'b0;
        end else begin
          if (src_calm > 0) src_calm--;
          s_tvalid <= 1'b1;
          s_tdata  <= rx_bytes_q.pop_front();
        end
      end
    end
  end

  // monitor: checks each result transfer and stalls in bursts until the tail
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected frame, kind", m_tuser, 0);
        end else begin
          arfp_pkg::result_t want;
          want = frames_due.pop_front();
          frames_seen++;
          if (want.has_status) status_seen++;
          if (m_tuser != want.frame_kind)
            report_mismatch("frame_kind", m_tuser, want.frame_kind);
          if (m_tdata[0] != want.has_status)
            report_mismatch("has_status", m_tdata[0], want.has_status);
          if (m_tdata[8:1] != want.volume)
            report_mismatch("volume", m_tdata[8:1], want.volume);
          if (m_tdata[11:9] != want.eq_mode)
            report_mismatch("eq_mode", m_tdata[11:9], want.eq_mode);
          if (m_tdata[15:12] != want.eq_nibble)
            report_mismatch("eq_nibble", m_tdata[15:12], want.eq_nibble);
          if (m_tdata[17:16] != want.source_sel)
            report_mismatch("source_sel", m_tdata[17:16], want.source_sel);
          if (m_tdata[21:18] != want.source_nibble)
            report_mismatch("source_nibble", m_tdata[21:18], want.source_nibble);
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else if (rx_bytes_q.size() > TAIL_BYTES && snk_calm == 0 &&
                   $urandom_range(0, 4) == 0) begin
        snk_gap  = $urandom_range(1, 10) - 1;
        snk_calm = $urandom_range(0, 30);
        m_tready <= 1'b0;
      end else begin
        if (snk_calm > 0) snk_calm--;
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_frame(input logic [7:0] hdr, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [7:0] csum_err);
    rx_bytes_q.push_back(hdr);
    rx_bytes_q.push_back(b1);
    rx_bytes_q.push_back(b2);
    rx_bytes_q.push_back(b3);
    rx_bytes_q.push_back(b1 ^ b2 ^ b3 ^ csum_err);
  endtask

  initial begin
    logic [7:0] hdr;
    logic [7:0] b2;
    logic [3:0] hi;
    logic [3:0] lo;
    logic [7:0] err;
    int unsigned pick;

    // directed: a junk byte ahead of the first frame forces one resync
    rx_bytes_q.push_back(8'h00);
    push_frame(arfp_pkg::HDR_STATUS, 8'h00, 8'h00, 8'h05, 8'h00);  // all-zero status, FM
    push_frame(arfp_pkg::HDR_EQ,     8'hFF, 8'h12, 8'h53, 8'h00);  // max volume, eq mode 5, MP3
    push_frame(arfp_pkg::HDR_DIR,    8'hFF, 8'hFF, 8'hFF, 8'h00);  // directory reply
    push_frame(arfp_pkg::HDR_STATUS, 8'h10, 8'hFF, 8'h46, 8'h00);  // no-status mark
    push_frame(arfp_pkg::HDR_STATUS, 8'h22, 8'h01, 8'h36, 8'h80);  // broken checksum
    push_frame(arfp_pkg::HDR_EQ,     8'h80, 8'h01, 8'hF6, 8'h00);  // unknown eq, DVD
    push_frame(8'h5A,                8'h00, 8'h00, 8'h00, 8'h00);  // bad header

    // random: mostly good frames, some broken ones and loose noise
    while (rx_bytes_q.size() < RANDOM_BYTES + 36) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       hdr = arfp_pkg::HDR_STATUS;
          1:       hdr = arfp_pkg::HDR_EQ;
          default: hdr = arfp_pkg::HDR_DIR;
        endcase
        b2 = ($urandom_range(0, 7) == 0) ? arfp_pkg::NO_STATUS_MARK : 8'($urandom);
        hi = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 6)) : 4'($urandom);
        case ($urandom_range(0, 4))
          0:       lo = arfp_pkg::SRC_NIB_FM;
          1:       lo = arfp_pkg::SRC_NIB_MP3;
          2:       lo = arfp_pkg::SRC_NIB_DVD;
          default: lo = 4'($urandom);
        endcase
        err = 8'h00;
        if (pick >= 70) err = 8'($urandom_range(1, 255));
        push_frame(hdr, 8'($urandom), b2, {hi, lo}, err);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 2) == 0)
            rx_bytes_q.push_back(($urandom_range(0, 1) == 0) ? arfp_pkg::HDR_STATUS :
                                                               arfp_pkg::HDR_DIR);
          else
            rx_bytes_q.push_back(8'($urandom));
        end
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_bytes_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (frames_due.size() != 0) report_mismatch("frames never reported", 0, 0);

    $display("sent %0d bytes, %0d frames came out, %0d of them with status fields",
             bytes_sent, frames_seen, status_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d bytes unsent and %0d frames outstanding",
             rx_bytes_q.size(), frames_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
sv/arfp_pkg.sv
sv/arfp_window.sv
sv/arfp_decode.sv
sv/audio_reply_frame_parser_core.sv
sv/arfp_checker.sv
tb/sv/tb_top.sv
